### hw/rtl/hskc_pkg.sv
`default_nettype none

package hskc_pkg;

    localparam int LEVEL_COUNT      = 10;
    localparam int BRANCH_BITS      = 2;
    localparam int CHUNK_BITS       = 12;
    localparam int MASTER_MAX_BYTES = 32;
    localparam int TOP_SHIFT        = CHUNK_BITS + BRANCH_BITS * (LEVEL_COUNT - 1);
    localparam int Y_W              = TOP_SHIFT - CHUNK_BITS;

    localparam logic [2:0] CFG_MASTER_LENGTH = 3'd0;
    localparam logic [2:0] CFG_MASTER_WORD0  = 3'd1;
    localparam logic [2:0] CFG_MASTER_WORD1  = 3'd2;
    localparam logic [2:0] CFG_MASTER_WORD2  = 3'd3;
    localparam logic [2:0] CFG_MASTER_WORD3  = 3'd4;

    localparam logic [5:0]  MASTER_LENGTH_RST = 6'd6;
    localparam logic [63:0] MASTER_WORD0_RST  = 64'h6D61737465720000;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT,
        ST_ERROR
    } t_state;

    typedef enum logic [1:0] {
        PH_INNER_KEY,
        PH_INNER_MSG,
        PH_OUTER_KEY,
        PH_OUTER_MSG
    } t_phase;

    typedef enum logic [1:0] {
        SH_IDLE,
        SH_ROUND,
        SH_ADD
    } t_sha_state;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    function automatic logic [4:0] level_shift(input logic [3:0] level);
        level_shift = 5'(CHUNK_BITS + BRANCH_BITS * (LEVEL_COUNT - 1 - int'(level)));
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hmac_sha1_offset_key_chain_core.sv
`default_nettype none

// For each offset transfer below 2^30 the core returns ten result transfers, one per tree
// level from the root, each carrying the HMAC-SHA1 key of that level, the block number and
// the byte range it covers; a larger offset gives one out_of_range result. Every level runs
// four SHA-1 compressions through a single round unit at one round per cycle; the input
// is not ready meanwhile.
// Configuration writes are accepted in any cycle and must only be issued while idle.

module hmac_sha1_offset_key_chain_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_level,
    output logic [17:0] o_block_number,
    output logic [29:0] o_range_first,
    output logic [29:0] o_range_final,
    output logic [31:0] o_key_top,
    output logic [63:0] o_key_middle,
    output logic [63:0] o_key_bottom,
    output logic        o_out_of_range,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import hskc_pkg::*;

    t_state       r_state, n_state;
    t_phase       r_phase;
    logic [3:0]   r_level;
    logic [5:0]   r_master_length;
    logic [63:0]  r_master_word [4];
    logic [TOP_SHIFT-1:0] r_offset;
    logic [511:0] r_key;
    logic [159:0] r_chain, r_inner, r_digest;

    logic         r_o_valid;
    logic [3:0]   r_o_level;
    logic [17:0]  r_o_block_number;
    logic [29:0]  r_o_range_first, r_o_range_final;
    logic [159:0] r_o_key;
    logic         r_o_oor, r_o_last;

    logic         w_accept, w_oor, w_slot_free, w_sha_start, w_sha_done;
    logic         w_emit, w_err_emit;
    logic [5:0]   w_plen;
    logic [255:0] w_master_all;
    logic [511:0] w_master_key, w_hex_key, w_block;
    logic [159:0] w_sha_h_in, w_sha_h_out;
    logic [4:0]   w_shift;
    logic [TOP_SHIFT:0]   w_low_mask;
    logic [TOP_SHIFT-1:0] w_y, w_first;
    logic [31:0]  w_word;
    logic [127:0] w_msg;

    assign w_accept    = i_valid && o_ready;
    assign w_oor       = (i_offset[31:TOP_SHIFT] != '0);
    assign w_slot_free = !r_o_valid || i_ready;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // level zero key from the master bytes in use
    always_comb begin
        w_plen = (r_master_length > 6'(MASTER_MAX_BYTES)) ? 6'(MASTER_MAX_BYTES)
                                                          : r_master_length;
        w_master_all = {r_master_word[0], r_master_word[1], r_master_word[2],
                        r_master_word[3]};
        w_master_key = '0;
        for (int i = 0; i < 32; i++) begin
            if (6'(i) < w_plen) begin
                w_master_key[511 - 8*i -: 8] = w_master_all[255 - 8*i -: 8];
            end
        end
    end

    // next level key is the hex text of the digest
    always_comb begin
        w_hex_key = '0;
        for (int i = 0; i < 40; i++) begin
            w_hex_key[511 - 8*i -: 8] = hex_char(r_digest[159 - 4*i -: 4]);
        end
    end

    always_comb begin
        w_shift    = level_shift(r_level);
        w_y        = r_offset >> w_shift;
        w_low_mask = ((TOP_SHIFT+1)'(1) << w_shift) - (TOP_SHIFT+1)'(1);
        w_first    = r_offset & ~w_low_mask[TOP_SHIFT-1:0];
        w_word     = {4'd0, r_level, 24'(w_y)};
        w_msg[127:64] = {8{8'h30}};
        for (int i = 0; i < 8; i++) begin
            w_msg[63 - 8*i -: 8] = hex_char(w_word[31 - 4*i -: 4]);
        end
    end

    always_comb begin
        case (r_phase)
            PH_INNER_KEY: w_block = r_key ^ {64{8'h36}};
            PH_INNER_MSG: w_block = {w_msg, 8'h80, 312'd0, 64'd640};
            PH_OUTER_KEY: w_block = r_key ^ {64{8'h5c}};
            PH_OUTER_MSG: w_block = {r_inner, 8'h80, 280'd0, 64'd672};
            default:      w_block = '0;
        endcase
        w_sha_h_in = (r_phase == PH_INNER_KEY || r_phase == PH_OUTER_KEY) ? SHA1_IV
                                                                           : r_chain;
    end

    hskc_sha1 u_sha1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sha_start),
        .i_block (w_block),
        .i_h     (w_sha_h_in),
        .o_done  (w_sha_done),
        .o_h     (w_sha_h_out)
    );

    always_comb begin
        n_state     = r_state;
        w_sha_start = 1'b0;
        w_emit      = 1'b0;
        w_err_emit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = w_oor ? ST_ERROR : ST_START;
            end
            ST_START: begin
                w_sha_start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_sha_done) n_state = (r_phase == PH_OUTER_MSG) ? ST_EMIT : ST_START;
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    w_emit  = 1'b1;
                    n_state = (r_level == 4'(LEVEL_COUNT - 1)) ? ST_IDLE : ST_START;
                end
            end
            ST_ERROR: begin
                if (w_slot_free) begin
                    w_err_emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_phase          <= PH_INNER_KEY;
            r_level          <= 4'd0;
            r_o_valid        <= 1'b0;
            r_master_length  <= MASTER_LENGTH_RST;
            r_master_word[0] <= MASTER_WORD0_RST;
            r_master_word[1] <= '0;
            r_master_word[2] <= '0;
            r_master_word[3] <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_phase <= PH_INNER_KEY;
                r_level <= 4'd0;
            end else begin
                if (w_sha_done) r_phase <= t_phase'(r_phase + 2'd1);
                if (w_emit) r_level <= r_level + 4'd1;
            end
            if (w_emit || w_err_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MASTER_LENGTH: r_master_length  <= i_cfg_data[5:0];
                    CFG_MASTER_WORD0:  r_master_word[0] <= i_cfg_data;
                    CFG_MASTER_WORD1:  r_master_word[1] <= i_cfg_data;
                    CFG_MASTER_WORD2:  r_master_word[2] <= i_cfg_data;
                    CFG_MASTER_WORD3:  r_master_word[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_offset <= i_offset[TOP_SHIFT-1:0];
            r_key    <= w_master_key;
        end else if (w_emit) begin
            r_key    <= w_hex_key;
        end
        if (w_sha_done) begin
            r_chain <= w_sha_h_out;
            if (r_phase == PH_INNER_MSG) r_inner  <= w_sha_h_out;
            if (r_phase == PH_OUTER_MSG) r_digest <= w_sha_h_out;
        end
        if (w_emit) begin
            r_o_level        <= r_level;
            r_o_block_number <= w_y[Y_W-1:0];
            r_o_range_first  <= w_first;
            r_o_range_final  <= w_first | w_low_mask[TOP_SHIFT-1:0];
            r_o_key          <= r_digest;
            r_o_oor          <= 1'b0;
            r_o_last         <= (r_level == 4'(LEVEL_COUNT - 1));
        end else if (w_err_emit) begin
            r_o_level        <= '0;
            r_o_block_number <= '0;
            r_o_range_first  <= '0;
            r_o_range_final  <= '0;
            r_o_key          <= '0;
            r_o_oor          <= 1'b1;
            r_o_last         <= 1'b1;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_level        = r_o_level;
    assign o_block_number = r_o_block_number;
    assign o_range_first  = r_o_range_first;
    assign o_range_final  = r_o_range_final;
    assign o_key_top      = r_o_key[159:128];
    assign o_key_middle   = r_o_key[127:64];
    assign o_key_bottom   = r_o_key[63:0];
    assign o_out_of_range = r_o_oor;
    assign o_last         = r_o_last;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sha_done |-> r_state == ST_WAIT)
        else $error("compression finished outside wait");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_level <= 4'(LEVEL_COUNT - 1))
        else $error("level beyond last");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit || w_err_emit) |-> (!r_o_valid || i_ready))
        else $error("result overwrote pending transfer");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_oor) |-> (r_o_key == '0 && r_o_last))
        else $error("error result not clean");

endmodule

`default_nettype wire

### hw/rtl/hskc_sha1.sv
`default_nettype none

module hskc_sha1 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [511:0] i_block,
    input  logic [159:0] i_h,
    output logic         o_done,
    output logic [159:0] o_h
);
    import hskc_pkg::*;

    t_sha_state  r_state, n_state;
    logic [6:0]  r_round;
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_h;
    logic        r_done;
    logic [31:0] w_f, w_k, w_t, w_next;

    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = 32'h5A827999;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = 32'h6ED9EBA1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = 32'h8F1BBCDC;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = 32'hCA62C1D6;
        end
        w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
        w_next = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_next = {w_next[30:0], w_next[31]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            SH_IDLE:  if (i_start) n_state = SH_ROUND;
            SH_ROUND: if (r_round == 7'd79) n_state = SH_ADD;
            SH_ADD:   n_state = SH_IDLE;
            default:  n_state = SH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SH_IDLE;
            r_done  <= 1'b0;
            r_round <= 7'd0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == SH_ADD);
            r_round <= (r_state == SH_ROUND) ? r_round + 7'd1 : 7'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SH_IDLE && i_start) begin
            for (int j = 0; j < 16; j++) begin
                r_w[j] <= i_block[511 - 32*j -: 32];
            end
            {r_a, r_b, r_c, r_d, r_e} <= i_h;
            r_h <= i_h;
        end else if (r_state == SH_ROUND) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= w_next;
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_t;
        end else if (r_state == SH_ADD) begin
            r_h <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                    r_h[63:32] + r_d, r_h[31:0] + r_e};
        end
    end

    assign o_done = r_done;
    assign o_h    = r_h;

endmodule

`default_nettype wire
